// ===== hdl/phc_pkg.sv =====
// Shared types, widths and the ones' complement add for the pseudo-header checksum block.
package phc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned ADDR_W = 32;

	localparam logic [WORD_W-1:0] WORD_ZERO = '0;

	// One byte transaction after the input register, with the header sum already folded.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              first_byte;
		logic              last_byte;
		logic [WORD_W-1:0] hdr_sum;
	} phc_item_t;

	// 16-bit ones' complement add with end-around carry.
	function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

endpackage

// ===== hdl/phc_if.sv =====
// Channel interfaces of the pseudo-header checksum block: byte input, result output, config.
interface phc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic        last_byte;
	logic [31:0] source_addr;
	logic [31:0] dest_addr;
	logic [7:0]  protocol;
	logic [15:0] payload_length;

	modport source(output valid, data_byte, first_byte, last_byte, source_addr, dest_addr,
		protocol, payload_length, input ready);
	modport sink(input valid, data_byte, first_byte, last_byte, source_addr, dest_addr,
		protocol, payload_length, output ready);
endinterface

interface phc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum_value;

	modport source(output valid, checksum_value, input ready);
	modport sink(input valid, checksum_value, output ready);
endinterface

interface phc_cfg_if;
	logic valid;
	logic ready;
	logic use_pseudo_header;

	modport source(output valid, use_pseudo_header, input ready);
	modport sink(input valid, use_pseudo_header, output ready);
endinterface

// ===== hdl/pseudo_header_internet_checksum_top.sv =====
// Top level of the Internet checksum block with optional TCP/UDP pseudo-header.
//
// Channels: in_ch carries one packet byte per transaction with first/last marks and the
// pseudo-header fields (sampled only with the first byte). out_ch carries one checksum
// per packet, produced by the transaction that carries the last byte. cfg_ch writes the
// use_pseudo_header register; it is always ready and must only be written while idle.
//
// Throughput: one byte per cycle while no last byte is held (see Stall). The running-sum
// feedback is a single 16-bit ones' complement add per cycle; the six-word header sum is
// folded in front of the input register, so it never sits in that loop.
// A last byte passes the input register; its checksum sits in the output register.
//
// Reset: clears the running sum, pairing phase and pending byte, empties both registers
// and sets use_pseudo_header to 1.
// Stall: while a checksum waits on out_ch, bytes that do not end a packet keep flowing;
// a last byte holds in the input register until the output register frees up, and
// in_ch.ready stays low for as long as it is held.
module pseudo_header_internet_checksum_top
	import phc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	phc_in_if.sink  in_ch,
	phc_out_if.source out_ch,
	phc_cfg_if.sink cfg_ch
);

	logic      use_pseudo_header_q;
	logic      valid_s1;
	phc_item_t item_s1;
	phc_item_t item_d;
	logic [WORD_W-1:0] hdr_sum;
	logic      in_accept;
	logic      advance;

	// Config register: always ready; it must be written only between packets, which the block does not enforce.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_pseudo_header_q <= 1'b1;
		end else if (cfg_ch.valid) begin
			use_pseudo_header_q <= cfg_ch.use_pseudo_header;
		end
	end

	// Fold the pseudo-header ahead of the input register.
	phc_hdr_sum u_hdr_sum (
		.enable         (use_pseudo_header_q),
		.source_addr    (in_ch.source_addr),
		.dest_addr      (in_ch.dest_addr),
		.protocol       (in_ch.protocol),
		.payload_length (in_ch.payload_length),
		.hdr_sum        (hdr_sum)
	);

	always_comb begin
		item_d.data_byte  = in_ch.data_byte;
		item_d.first_byte = in_ch.first_byte;
		item_d.last_byte  = in_ch.last_byte;
		item_d.hdr_sum    = hdr_sum;
	end

	// Advance the input register unless it holds a last byte and the result slot is busy.
	assign advance   = valid_s1 && (!item_s1.last_byte || !out_ch.valid || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_accept = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= item_d;
		end
	end

	phc_accum u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.item_s1        (item_s1),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.checksum_value (out_ch.checksum_value)
	);

`ifndef SYNTHESIS
	// A last byte that moves on must produce a result in the next cycle.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.last_byte) |=> out_ch.valid)
		else $error("last byte advanced without a result");

	// Never overwrite an unread result.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.last_byte) |-> (!out_ch.valid || out_ch.ready))
		else $error("result overwritten while stalled");

	// Backpressure only comes from a held input register.
	a_ready_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (valid_s1 && item_s1.last_byte && out_ch.valid && !out_ch.ready))
		else $error("input stalled without cause");
`endif

endmodule

// ===== hdl/phc_hdr_sum.sv =====
// Folded ones' complement sum of the six TCP/UDP pseudo-header words, or zero when disabled.
module phc_hdr_sum
	import phc_pkg::*;
(
	input  logic              enable,
	input  logic [ADDR_W-1:0] source_addr,
	input  logic [ADDR_W-1:0] dest_addr,
	input  logic [BYTE_W-1:0] protocol,
	input  logic [WORD_W-1:0] payload_length,
	output logic [WORD_W-1:0] hdr_sum
);

	// Six 16-bit words sum to less than 2^19.
	logic [WORD_W+2:0] raw;
	logic [WORD_W:0]   fold1;
	logic [WORD_W-1:0] fold2;

	always_comb begin
		raw = {3'b000, source_addr[ADDR_W-1:WORD_W]}
			+ {3'b000, source_addr[WORD_W-1:0]}
			+ {3'b000, dest_addr[ADDR_W-1:WORD_W]}
			+ {3'b000, dest_addr[WORD_W-1:0]}
			+ {{(WORD_W-BYTE_W+3){1'b0}}, protocol}
			+ {3'b000, payload_length};
		// Fold the carries back in twice; the second fold cannot carry again.
		fold1 = {1'b0, raw[WORD_W-1:0]} + {{(WORD_W-2){1'b0}}, raw[WORD_W+2:WORD_W]};
		fold2 = fold1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold1[WORD_W]};
		hdr_sum = enable ? fold2 : WORD_ZERO;
	end

endmodule

// ===== hdl/phc_accum.sv =====
// Running checksum state, byte pairing and the registered result.
module phc_accum
	import phc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  phc_item_t         item_s1,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [WORD_W-1:0] checksum_value
);

	logic [WORD_W-1:0] running_sum_q;
	logic [BYTE_W-1:0] pending_q;
	logic              odd_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] checksum_q;

	logic [WORD_W-1:0] base;
	logic [BYTE_W-1:0] pend;
	logic              phase;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] new_sum;

	always_comb begin
		base  = item_s1.first_byte ? item_s1.hdr_sum : running_sum_q;
		pend  = item_s1.first_byte ? '0 : pending_q;
		phase = item_s1.first_byte ? 1'b0 : odd_q;
		if (phase) begin
			word = {pend, item_s1.data_byte};
		end else if (item_s1.last_byte) begin
			word = {item_s1.data_byte, {BYTE_W{1'b0}}};
		end else begin
			word = WORD_ZERO;
		end
		new_sum = oc_add(base, word);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			pending_q     <= '0;
			odd_q         <= 1'b0;
		end else if (advance) begin
			if (item_s1.last_byte || phase) begin
				running_sum_q <= item_s1.last_byte ? WORD_ZERO : new_sum;
				pending_q     <= '0;
				odd_q         <= 1'b0;
			end else begin
				running_sum_q <= new_sum;
				pending_q     <= item_s1.data_byte;
				odd_q         <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			checksum_q <= ~new_sum;
		end
	end

	assign out_valid      = out_valid_q;
	assign checksum_value = checksum_q;

endmodule

// ===== dv/tb_pseudo_header_internet_checksum_top.sv =====
// Testbench for the pseudo-header Internet checksum block: byte stimulus, prediction, checks.
module tb_pseudo_header_internet_checksum_top;
	timeunit 1ns;
	timeprecision 1ps;

	import phc_pkg::*;

	// One byte transaction as the sender offers it on in_ch.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              first;
		logic              last;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [BYTE_W-1:0] proto;
		logic [WORD_W-1:0] plen;
	} pkt_byte_t;

	// How a generated packet is marked: clean, or one of the broken shapes.
	typedef enum int {
		PKT_CLEAN,
		PKT_NO_FIRST,
		PKT_NO_LAST,
		PKT_SCRAMBLED
	} pkt_shape_t;

	localparam int HOLD_CYCLES   = 80;
	localparam int DRAIN_CYCLES  = 6;

	logic clk = 1'b0;
	logic arst_n;

	phc_in_if  in_ch();
	phc_out_if out_ch();
	phc_cfg_if cfg_ch();

	pseudo_header_internet_checksum_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// 12 ns clock: low half, then high half.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Bytes waiting to be offered, and checksums waiting to come out.
	pkt_byte_t   pending_bytes[$];
	logic [15:0] expected_checksums[$];
	int          errors = 0;

	// Predictor copy of the block state and its use_pseudo_header register.
	logic        hdr_mode = 1'b1;
	logic [15:0] sum_acc = '0;
	logic [7:0]  high_byte = '0;
	logic        odd_half = 1'b0;

	// Idling knobs, set per phase by the stimulus process.
	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	bit hold_request = 1'b0;

	// Driver and receiver bookkeeping.
	logic      byte_taken = 1'b0;
	bit        offering = 1'b0;
	int        gap_left = 0;
	pkt_byte_t cur_byte;
	bit        hold_served = 1'b0;
	int        hold_left = 0;
	int        stall_left = 0;

	// 16-bit ones' complement add, carry wrapped back into bit 0.
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// Advance the predicted state by one accepted byte; queue a checksum on a last byte.
	function automatic void checksum_step(input pkt_byte_t b);
		if (b.first) begin
			sum_acc = '0;
			high_byte = '0;
			odd_half = 1'b0;
			if (hdr_mode) begin
				sum_acc = ones_add(sum_acc, b.src[31:16]);
				sum_acc = ones_add(sum_acc, b.src[15:0]);
				sum_acc = ones_add(sum_acc, b.dst[31:16]);
				sum_acc = ones_add(sum_acc, b.dst[15:0]);
				sum_acc = ones_add(sum_acc, {8'd0, b.proto});
				sum_acc = ones_add(sum_acc, b.plen);
			end
		end
		if (!odd_half) begin
			high_byte = b.data;
			odd_half = 1'b1;
		end else begin
			sum_acc = ones_add(sum_acc, {high_byte, b.data});
			high_byte = '0;
			odd_half = 1'b0;
		end
		if (b.last) begin
			// pad a trailing odd byte with a zero low byte
			if (odd_half)
				sum_acc = ones_add(sum_acc, {high_byte, 8'd0});
			expected_checksums.push_back(~sum_acc);
			sum_acc = '0;
			high_byte = '0;
			odd_half = 1'b0;
		end
	endfunction

	// Register the input handshake so the driver sees it at the next falling edge.
	always @(posedge clk)
		byte_taken <= arst_n && in_ch.valid && in_ch.ready;

	// Monitor: predict on every accepted byte, track register writes, check every checksum.
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				checksum_step('{in_ch.data_byte, in_ch.first_byte, in_ch.last_byte,
					in_ch.source_addr, in_ch.dest_addr, in_ch.protocol,
					in_ch.payload_length});
			if (cfg_ch.valid && cfg_ch.ready)
				hdr_mode = cfg_ch.use_pseudo_header;
			if (out_ch.valid && out_ch.ready) begin
				if (expected_checksums.size() == 0) begin
					$display("%0t: checksum %h with none expected", $time,
						out_ch.checksum_value);
					errors++;
				end else begin
					want = expected_checksums.pop_front();
					if (out_ch.checksum_value !== want) begin
						$display("%0t: checksum mismatch, expected %h, got %h", $time,
							want, out_ch.checksum_value);
						errors++;
					end
				end
			end
		end
	end

	// Driver: hold each byte until it is taken, then insert an idle burst now and then.
	always @(negedge clk) begin
		if (arst_n) begin
			if (byte_taken)
				offering = 1'b0;
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
					gap_left = $urandom_range(1, 11) - 1;
				end else if (pending_bytes.size() > 0) begin
					cur_byte = pending_bytes.pop_front();
					offering = 1'b1;
				end
			end
			in_ch.valid          <= offering;
			in_ch.data_byte      <= cur_byte.data;
			in_ch.first_byte     <= cur_byte.first;
			in_ch.last_byte      <= cur_byte.last;
			in_ch.source_addr    <= cur_byte.src;
			in_ch.dest_addr      <= cur_byte.dst;
			in_ch.protocol       <= cur_byte.proto;
			in_ch.payload_length <= cur_byte.plen;
		end
	end

	// Receiver: one long hold-off on request, otherwise random stall bursts.
	always @(negedge clk) begin
		logic take;
		take = 1'b1;
		if (hold_request && !hold_served) begin
			hold_served = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			take = 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			take = 1'b0;
			stall_left--;
		end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
			take = 1'b0;
			stall_left = $urandom_range(1, 11) - 1;
		end
		out_ch.ready <= take;
	end

	// Queue one byte transaction for the driver.
	task automatic push_byte(input logic [7:0] data, input logic first, input logic last,
		input logic [31:0] src, input logic [31:0] dst, input logic [7:0] proto,
		input logic [15:0] plen);
		pending_bytes.push_back('{data, first, last, src, dst, proto, plen});
	endtask

	// Address-sized field, biased toward all zeros and all ones to hit the carry paths.
	function automatic logic [31:0] pick_addr();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Queue one packet of random content, marked according to its shape.
	task automatic push_packet(input int len, input pkt_shape_t shape);
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  proto;
		logic [15:0] plen;
		logic        first;
		logic        last;
		for (int i = 0; i < len; i++) begin
			src = pick_addr();
			dst = pick_addr();
			proto = 8'($urandom_range(0, 255));
			// mostly the true length, sometimes anything at all
			plen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(len);
			case (shape)
				PKT_NO_FIRST: begin
					first = 1'b0;
					last = (i == len - 1);
				end
				PKT_NO_LAST: begin
					first = (i == 0);
					last = 1'b0;
				end
				PKT_SCRAMBLED: begin
					first = ($urandom_range(0, 3) == 0);
					last = ($urandom_range(0, 3) == 0);
				end
				default: begin
					first = (i == 0);
					last = (i == len - 1);
				end
			endcase
			push_byte(8'($urandom_range(0, 255)), first, last, src, dst, proto, plen);
		end
	endtask

	// Fill the queue with about n_bytes of mostly clean packets and some broken ones.
	task automatic push_random_traffic(input int n_bytes);
		int         queued;
		int         len;
		pkt_shape_t shape;
		queued = 0;
		while (queued < n_bytes) begin
			// mostly short packets so results come often; a few long ones
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 12);
			case ($urandom_range(0, 9))
				0:       shape = PKT_NO_FIRST;
				1:       shape = PKT_NO_LAST;
				2:       shape = PKT_SCRAMBLED;
				default: shape = PKT_CLEAN;
			endcase
			push_packet(len, shape);
			queued += len;
		end
	endtask

	// Wait until every byte is taken and every checksum has come out, then let the
	// pipeline settle, since a byte without a last mark leaves no result to wait for.
	task automatic drain();
		while (pending_bytes.size() > 0 || offering || expected_checksums.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write use_pseudo_header through the config channel; only called while idle.
	task automatic write_hdr_mode(input logic mode);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.use_pseudo_header <= mode;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Main sequence: reset, directed packets under both modes, then random phases.
	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.first_byte = 1'b0;
		in_ch.last_byte = 1'b0;
		in_ch.source_addr = '0;
		in_ch.dest_addr = '0;
		in_ch.protocol = '0;
		in_ch.payload_length = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.use_pseudo_header = 1'b0;
		cur_byte = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, pseudo-header on from reset.
		// One-byte packet with every field at its top value.
		push_byte(8'hff, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff);
		// One-byte packet, everything zero.
		push_byte(8'h00, 1'b1, 1'b1, 32'h0, 32'h0, 8'h00, 16'h0000);
		// Even packet, typical TCP header fields.
		push_byte(8'h45, 1'b1, 1'b0, 32'hc0a8_0001, 32'hc0a8_00c7, 8'h06, 16'h0002);
		push_byte(8'h00, 1'b0, 1'b1, 32'h0, 32'h0, 8'h00, 16'h0000);
		// Odd packet: the trailing byte is padded.
		push_byte(8'hff, 1'b1, 1'b0, 32'h8000_0001, 32'h0001_8000, 8'h11, 16'h0003);
		push_byte(8'hff, 1'b0, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff);
		push_byte(8'hff, 1'b0, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff);
		// Bytes after a last byte with no first mark: summed without header words.
		push_byte(8'hab, 1'b0, 1'b0, 32'h1234_5678, 32'h9abc_def0, 8'h06, 16'h0002);
		push_byte(8'hcd, 1'b0, 1'b1, 32'h1234_5678, 32'h9abc_def0, 8'h06, 16'h0002);
		// A first mark in mid-packet restarts the sum.
		push_byte(8'h12, 1'b1, 1'b0, 32'h0a00_0001, 32'h0a00_0002, 8'h06, 16'h0004);
		push_byte(8'h34, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
		push_byte(8'h56, 1'b1, 1'b0, 32'h0a00_0003, 32'h0a00_0004, 8'h11, 16'h0000);
		push_byte(8'h78, 1'b0, 1'b1, 32'h0, 32'h0, 8'h00, 16'h0000);
		// Payload length that does not match the byte count.
		push_byte(8'h01, 1'b1, 1'b0, 32'hfffe_0001, 32'h0001_fffe, 8'h00, 16'hffff);
		push_byte(8'h02, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
		push_byte(8'h03, 1'b0, 1'b1, 32'h0, 32'h0, 8'h00, 16'h0000);
		drain();

		// Directed, payload only: header fields must be ignored.
		write_hdr_mode(1'b0);
		push_byte(8'hff, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff);
		push_byte(8'hff, 1'b1, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff);
		push_byte(8'hff, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
		push_byte(8'h00, 1'b0, 1'b1, 32'h0, 32'h0, 8'h00, 16'h0000);
		push_byte(8'h00, 1'b1, 1'b1, 32'h0, 32'h0, 8'h00, 16'h0000);
		// Leave a packet open across the mode change below.
		push_byte(8'h5a, 1'b1, 1'b0, 32'h0102_0304, 32'h0506_0708, 8'h06, 16'h0001);
		drain();

		// Random, header on, idling on both sides plus one long receiver hold-off
		// while the sender keeps offering, so the block backs up and stalls in_ch.
		write_hdr_mode(1'b1);
		src_gap_pct = 20;
		sink_stall_pct = 20;
		hold_request = 1'b1;
		push_random_traffic(250);
		drain();

		// Random, payload only, heavy output stalls and light input gaps.
		write_hdr_mode(1'b0);
		src_gap_pct = 10;
		sink_stall_pct = 40;
		push_random_traffic(200);
		drain();

		// Random, header on, no idling at all to run at full rate.
		write_hdr_mode(1'b1);
		src_gap_pct = 0;
		sink_stall_pct = 0;
		push_random_traffic(250);
		drain();

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/phc_pkg.sv
hdl/phc_if.sv
hdl/phc_hdr_sum.sv
hdl/phc_accum.sv
hdl/pseudo_header_internet_checksum_top.sv
dv/tb_pseudo_header_internet_checksum_top.sv
